@@ design/assert_macros.svh @@
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that prop holds at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cond never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

@@ design/cau_pkg.sv @@
package cau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
        logic neg_re;
        logic neg_im;
        logic den_zero;
    } t_ctrl;

endpackage

@@ design/cau_req_if.sv @@
interface cau_req_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;

    modport source (output valid, req_type, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, req_type, a_real, a_imag, b_real, b_imag, output ready);
endinterface

@@ design/cau_rsp_if.sv @@
interface cau_rsp_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_real;
    logic signed [DATA_WIDTH-1:0] res_imag;
    logic                         overflow;
    logic                         div_zero;

    modport source (output valid, res_real, res_imag, overflow, div_zero, input ready);
    modport sink   (input valid, res_real, res_imag, overflow, div_zero, output ready);
endinterface

@@ design/cau_front.sv @@
// Two stages: partial products, then signed combine into sign and magnitude.
module cau_front #(
    parameter int DW = 16,
    parameter int PW = 2 * DW,
    parameter int MW = 2 * DW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  cau_pkg::t_op         i_op,
    input  logic signed [DW-1:0] i_a_real,
    input  logic signed [DW-1:0] i_a_imag,
    input  logic signed [DW-1:0] i_b_real,
    input  logic signed [DW-1:0] i_b_imag,
    output cau_pkg::t_ctrl       o_ctrl,
    output logic [MW-1:0]        o_mag_re,
    output logic [MW-1:0]        o_mag_im,
    output logic [PW-1:0]        o_den
);

    logic                 r_s1_valid;
    cau_pkg::t_op         r_s1_op;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;
    logic signed [DW:0]   r_lin_re, r_lin_im;

    logic signed [DW:0]   n_lin_re, n_lin_im;
    logic signed [MW-1:0] v_re, v_im;
    logic [PW-1:0]        den;

    cau_pkg::t_ctrl       r_ctrl;
    logic [MW-1:0]        r_mag_re, r_mag_im;
    logic [PW-1:0]        r_den;

    function automatic logic signed [MW-1:0] ext(input logic signed [PW-1:0] x);
        return $signed({{(MW - PW){x[PW-1]}}, x});
    endfunction

    always_comb begin
        if (i_op == cau_pkg::OP_SUB) begin
            n_lin_re = $signed({i_a_real[DW-1], i_a_real}) - $signed({i_b_real[DW-1], i_b_real});
            n_lin_im = $signed({i_a_imag[DW-1], i_a_imag}) - $signed({i_b_imag[DW-1], i_b_imag});
        end else begin
            n_lin_re = $signed({i_a_real[DW-1], i_a_real}) + $signed({i_b_real[DW-1], i_b_real});
            n_lin_im = $signed({i_a_imag[DW-1], i_a_imag}) + $signed({i_b_imag[DW-1], i_b_imag});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_op  <= i_op;
            r_p_rr   <= i_a_real * i_b_real;
            r_p_ii   <= i_a_imag * i_b_imag;
            r_p_ri   <= i_a_real * i_b_imag;
            r_p_ir   <= i_a_imag * i_b_real;
            r_sq_r   <= i_b_real * i_b_real;
            r_sq_i   <= i_b_imag * i_b_imag;
            r_lin_re <= n_lin_re;
            r_lin_im <= n_lin_im;
        end
    end

    always_comb begin
        den = PW'(r_sq_r) + PW'(r_sq_i);
        unique case (r_s1_op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
                v_re = $signed({{(MW - DW - 1){r_lin_re[DW]}}, r_lin_re});
                v_im = $signed({{(MW - DW - 1){r_lin_im[DW]}}, r_lin_im});
            end
            cau_pkg::OP_MUL: begin
                v_re = ext(r_p_rr) - ext(r_p_ii);
                v_im = ext(r_p_ri) + ext(r_p_ir);
            end
            cau_pkg::OP_DIV: begin
                // numerator of a * conj(b)
                v_re = ext(r_p_rr) + ext(r_p_ii);
                v_im = ext(r_p_ir) - ext(r_p_ri);
            end
            default: begin
                v_re = '0;
                v_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctrl.valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctrl.op       <= r_s1_op;
            r_ctrl.neg_re   <= v_re[MW-1];
            r_ctrl.neg_im   <= v_im[MW-1];
            r_ctrl.den_zero <= (r_s1_op == cau_pkg::OP_DIV) && (den == '0);
            r_mag_re        <= v_re[MW-1] ? MW'(-v_re) : MW'(v_re);
            r_mag_im        <= v_im[MW-1] ? MW'(-v_im) : MW'(v_im);
            r_den           <= den;
        end
    end

    assign o_ctrl   = r_ctrl;
    assign o_mag_re = r_mag_re;
    assign o_mag_im = r_mag_im;
    assign o_den    = r_den;

endmodule

@@ design/cau_divider.sv @@
// Restoring divider, one quotient bit per stage, two lanes in lockstep.
// Stage 0 flags quotients too large for QW bits; later stages resolve bits.
module cau_divider #(
    parameter int DW = 16,
    parameter int FB = 8,
    parameter int PW = 2 * DW,
    parameter int MW = 2 * DW + 1,
    parameter int QW = DW + 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  cau_pkg::t_ctrl i_ctrl,
    input  logic [MW-1:0]  i_mag_re,
    input  logic [MW-1:0]  i_mag_im,
    input  logic [PW-1:0]  i_den,
    output cau_pkg::t_ctrl o_ctrl,
    output logic [MW-1:0]  o_mag_re,
    output logic [MW-1:0]  o_mag_im,
    output logic [QW-1:0]  o_q_re,
    output logic [QW-1:0]  o_q_im,
    output logic           o_ov_re,
    output logic           o_ov_im
);

    localparam int NS = QW + 1;
    localparam int NW = MW + FB;
    localparam int HW = NW - QW;
    localparam int CW = (HW > PW) ? HW : PW;

    cau_pkg::t_ctrl r_ctrl [0:NS-1];
    logic [PW-1:0]  r_den  [0:NS-1];
    logic [MW-1:0]  r_mag  [0:NS-1][0:1];
    logic [PW-1:0]  r_rem  [0:NS-1][0:1];
    logic [QW-1:0]  r_q    [0:NS-1][0:1];
    logic           r_ov   [0:NS-1][0:1];

    logic [MW-1:0]  in_mag [0:1];

    assign in_mag[0] = i_mag_re;
    assign in_mag[1] = i_mag_im;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctrl[s].valid <= 1'b0;
            end else if (i_en) begin
                r_ctrl[s].valid <= (s == 0) ? i_ctrl.valid : r_ctrl[(s == 0) ? 0 : s - 1].valid;
            end
        end

        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ctrl[0].op       <= i_ctrl.op;
                    r_ctrl[0].neg_re   <= i_ctrl.neg_re;
                    r_ctrl[0].neg_im   <= i_ctrl.neg_im;
                    r_ctrl[0].den_zero <= i_ctrl.den_zero;
                    r_den[0]           <= i_den;
                end
            end

            for (genvar l = 0; l < 2; l++) begin : g_lane
                logic [NW-1:0] num;
                logic [HW-1:0] hi;
                logic          ov;

                assign num = NW'(in_mag[l]) << FB;
                assign hi  = num[NW-1:QW];
                assign ov  = CW'(hi) >= CW'(i_den);

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_mag[0][l] <= in_mag[l];
                        r_ov[0][l]  <= ov;
                        r_rem[0][l] <= ov ? '0 : PW'(hi);
                        r_q[0][l]   <= '0;
                    end
                end
            end
        end else begin : g_step
            localparam int J = QW - s;

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ctrl[s].op       <= r_ctrl[s-1].op;
                    r_ctrl[s].neg_re   <= r_ctrl[s-1].neg_re;
                    r_ctrl[s].neg_im   <= r_ctrl[s-1].neg_im;
                    r_ctrl[s].den_zero <= r_ctrl[s-1].den_zero;
                    r_den[s]           <= r_den[s-1];
                end
            end

            for (genvar l = 0; l < 2; l++) begin : g_lane
                logic          nbit;
                logic [PW:0]   part;
                logic          ge;

                if (J >= FB) begin : g_bit
                    assign nbit = r_mag[s-1][l][J-FB];
                end else begin : g_zero
                    assign nbit = 1'b0;
                end

                assign part = {r_rem[s-1][l], nbit};
                assign ge   = part >= {1'b0, r_den[s-1]};

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_mag[s][l] <= r_mag[s-1][l];
                        r_ov[s][l]  <= r_ov[s-1][l];
                        r_rem[s][l] <= ge ? PW'(part - {1'b0, r_den[s-1]}) : PW'(part);
                        r_q[s][l]   <= {r_q[s-1][l][QW-2:0], ge};
                    end
                end
            end
        end
    end

    assign o_ctrl   = r_ctrl[NS-1];
    assign o_mag_re = r_mag[NS-1][0];
    assign o_mag_im = r_mag[NS-1][1];
    assign o_q_re   = r_q[NS-1][0];
    assign o_q_im   = r_q[NS-1][1];
    assign o_ov_re  = r_ov[NS-1][0];
    assign o_ov_im  = r_ov[NS-1][1];

endmodule

@@ design/cau_back.sv @@
// Result select, truncation, saturation and the output register.
module cau_back #(
    parameter int DW = 16,
    parameter int FB = 8,
    parameter int MW = 2 * DW + 1,
    parameter int QW = DW + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  cau_pkg::t_ctrl       i_ctrl,
    input  logic [MW-1:0]        i_mag_re,
    input  logic [MW-1:0]        i_mag_im,
    input  logic [QW-1:0]        i_q_re,
    input  logic [QW-1:0]        i_q_im,
    input  logic                 i_ov_re,
    input  logic                 i_ov_im,
    output logic                 o_valid,
    output logic signed [DW-1:0] o_res_real,
    output logic signed [DW-1:0] o_res_imag,
    output logic                 o_overflow,
    output logic                 o_div_zero
);

    localparam logic [MW-1:0] LIM = MW'(1) << (DW - 1);

    logic                 r_valid;
    logic signed [DW-1:0] r_res_real, r_res_imag;
    logic                 r_overflow, r_div_zero;

    logic [MW-1:0]        fin_re, fin_im;
    logic [DW:0]          sat_re, sat_im;

    function automatic logic [MW-1:0] pick(input cau_pkg::t_op op, input logic [MW-1:0] mag,
                                           input logic [QW-1:0] q, input logic ov);
        logic [MW-1:0] v;
        unique case (op)
            cau_pkg::OP_DIV: v = ov ? '1 : MW'(q);
            cau_pkg::OP_MUL: v = mag >> FB;
            default:         v = mag;
        endcase
        return v;
    endfunction

    // returns {overflow, value}
    function automatic logic [DW:0] sat(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] neg_mag;
        logic [DW:0]   r;
        neg_mag = MW'(-mag);
        if (neg) begin
            if (mag > LIM) r = {1'b1, LIM[DW-1:0]};
            else           r = {1'b0, neg_mag[DW-1:0]};
        end else begin
            if (mag >= LIM) r = {1'b1, DW'(LIM - MW'(1))};
            else            r = {1'b0, mag[DW-1:0]};
        end
        return r;
    endfunction

    always_comb begin
        fin_re = pick(i_ctrl.op, i_mag_re, i_q_re, i_ov_re);
        fin_im = pick(i_ctrl.op, i_mag_im, i_q_im, i_ov_im);
        sat_re = sat(i_ctrl.neg_re, fin_re);
        sat_im = sat(i_ctrl.neg_im, fin_im);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ctrl.den_zero) begin
                r_res_real <= '0;
                r_res_imag <= '0;
                r_overflow <= 1'b0;
            end else begin
                r_res_real <= $signed(sat_re[DW-1:0]);
                r_res_imag <= $signed(sat_im[DW-1:0]);
                r_overflow <= sat_re[DW] | sat_im[DW];
            end
            r_div_zero <= i_ctrl.den_zero;
        end
    end

    assign o_valid    = r_valid;
    assign o_res_real = r_res_real;
    assign o_res_imag = r_res_imag;
    assign o_overflow = r_overflow;
    assign o_div_zero = r_div_zero;

endmodule

@@ design/complex_arithmetic_unit.sv @@
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// i_req carries req_type and the operands a and b; o_rsp carries the result,
// an overflow flag (either part saturated) and a divide-by-zero flag.
// Both channels move a transaction when valid and ready are high together.
// Pipeline: two stages for products and combine, DATA_WIDTH + 2 divider
// stages (an overflow check, then one quotient bit each) and one output
// stage, the same path for every operation. One transaction can enter every
// cycle, and one result can leave every cycle, unless the output is stalled.
// Divide truncates toward zero; a zero divisor gives a zero result with
// div_zero set. Multiply truncates the product toward zero.
// When the receiver holds ready low while a result is waiting, the whole
// pipeline freezes and i_req.ready drops in the same cycle; nothing is lost.
// Synchronous reset clears all valid bits; no result is pending afterward.
`include "assert_macros.svh"

module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cau_req_if.sink        i_req,
    cau_rsp_if.source      o_rsp
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;
    localparam int MW = 2 * DW + 1;
    localparam int QW = DW + 1;
    localparam logic signed [DW-1:0] MAX_VAL = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] MIN_VAL = {1'b1, {(DW - 1){1'b0}}};

    logic           en;
    logic           out_valid;

    cau_pkg::t_ctrl fr_ctrl, dv_ctrl;
    logic [MW-1:0]  fr_mag_re, fr_mag_im, dv_mag_re, dv_mag_im;
    logic [PW-1:0]  fr_den;
    logic [QW-1:0]  dv_q_re, dv_q_im;
    logic           dv_ov_re, dv_ov_im;

    // advance everything unless a finished result is held by the receiver
    assign en          = !out_valid || o_rsp.ready;
    assign i_req.ready = en;
    assign o_rsp.valid = out_valid;

    cau_front #(.DW(DW), .PW(PW), .MW(MW)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_req.valid),
        .i_op     (cau_pkg::t_op'(i_req.req_type)),
        .i_a_real (i_req.a_real),
        .i_a_imag (i_req.a_imag),
        .i_b_real (i_req.b_real),
        .i_b_imag (i_req.b_imag),
        .o_ctrl   (fr_ctrl),
        .o_mag_re (fr_mag_re),
        .o_mag_im (fr_mag_im),
        .o_den    (fr_den)
    );

    cau_divider #(.DW(DW), .FB(FRAC_BITS), .PW(PW), .MW(MW), .QW(QW)) u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctrl   (fr_ctrl),
        .i_mag_re (fr_mag_re),
        .i_mag_im (fr_mag_im),
        .i_den    (fr_den),
        .o_ctrl   (dv_ctrl),
        .o_mag_re (dv_mag_re),
        .o_mag_im (dv_mag_im),
        .o_q_re   (dv_q_re),
        .o_q_im   (dv_q_im),
        .o_ov_re  (dv_ov_re),
        .o_ov_im  (dv_ov_im)
    );

    cau_back #(.DW(DW), .FB(FRAC_BITS), .MW(MW), .QW(QW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_ctrl     (dv_ctrl),
        .i_mag_re   (dv_mag_re),
        .i_mag_im   (dv_mag_im),
        .i_q_re     (dv_q_re),
        .i_q_im     (dv_q_im),
        .i_ov_re    (dv_ov_re),
        .i_ov_im    (dv_ov_im),
        .o_valid    (out_valid),
        .o_res_real (o_rsp.res_real),
        .o_res_imag (o_rsp.res_imag),
        .o_overflow (o_rsp.overflow),
        .o_div_zero (o_rsp.div_zero)
    );

    `ASSERT_CLK(a_dz_zero, i_clk, i_rst_n, (o_rsp.valid && o_rsp.div_zero) |-> (o_rsp.res_real == '0 && o_rsp.res_imag == '0 && !o_rsp.overflow), "divide by zero result not cleared")
    `ASSERT_CLK(a_stall_blocks, i_clk, i_rst_n, (o_rsp.valid && !o_rsp.ready) |-> !i_req.ready, "input taken while output stalled")
    `ASSERT_NEVER(a_ovf_at_limit, i_clk, i_rst_n, o_rsp.valid && o_rsp.overflow && o_rsp.res_real != MAX_VAL && o_rsp.res_real != MIN_VAL && o_rsp.res_imag != MAX_VAL && o_rsp.res_imag != MIN_VAL, "overflow flagged without a saturated part")

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 16;
    localparam int FB = 8;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
        logic                 ovf;
        logic                 dz;
    } t_cplx_res;

    // Bit-exact model of the complex unit; one expected result per request.
    class cplx_scoreboard;
        t_cplx_res pending[$];
        int        n_err;

        function automatic logic signed [DW-1:0] clamp(longint v, output logic ovf);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (DW - 1)) - 1;
            lo = -(longint'(1) <<< (DW - 1));
            ovf = 1'b0;
            if (v > hi) begin
                ovf = 1'b1;
                return hi[DW-1:0];
            end
            if (v < lo) begin
                ovf = 1'b1;
                return lo[DW-1:0];
            end
            return v[DW-1:0];
        endfunction

        // Truncate toward zero: work on the magnitude.
        function automatic longint shr_tz(longint v);
            return (v < 0) ? -((-v) >>> FB) : (v >>> FB);
        endfunction

        function automatic longint div_tz(longint num, longint den);
            longint m;
            longint q;
            m = (num < 0) ? -num : num;
            q = (m <<< FB) / den;
            return (num < 0) ? -q : q;
        endfunction

        function void note_request(cau_pkg::t_op op, logic signed [DW-1:0] ar, ai, br, bi);
            t_cplx_res r;
            longint    xr, xi, xar, xai, xbr, xbi, den;
            logic      ovf_re, ovf_im;
            xar = ar; xai = ai; xbr = br; xbi = bi;
            r = '0;
            xr = 0; xi = 0;
            case (op)
                cau_pkg::OP_ADD: begin xr = xar + xbr; xi = xai + xbi; end
                cau_pkg::OP_SUB: begin xr = xar - xbr; xi = xai - xbi; end
                cau_pkg::OP_MUL: begin
                    xr = shr_tz(xar * xbr - xai * xbi);
                    xi = shr_tz(xar * xbi + xai * xbr);
                end
                default: begin
                    den = xbr * xbr + xbi * xbi;
                    if (den == 0) r.dz = 1'b1;
                    else begin
                        xr = div_tz(xar * xbr + xai * xbi, den);
                        xi = div_tz(xai * xbr - xar * xbi, den);
                    end
                end
            endcase
            r.re = clamp(xr, ovf_re);
            r.im = clamp(xi, ovf_im);
            r.ovf = ovf_re | ovf_im;
            pending = {pending, r};
        endfunction

        function void check_result(logic signed [DW-1:0] re, im, logic ovf, dz);
            t_cplx_res e;
            if (pending.size() == 0) begin
                $error("unexpected result re=%0d im=%0d", re, im);
                n_err++;
                return;
            end
            e = pending.pop_front();
            if (re !== e.re) begin
                $error("res_real: expected %0d, got %0d", e.re, re); n_err++;
            end
            if (im !== e.im) begin
                $error("res_imag: expected %0d, got %0d", e.im, im); n_err++;
            end
            if (ovf !== e.ovf) begin
                $error("overflow: expected %0b, got %0b", e.ovf, ovf); n_err++;
            end
            if (dz !== e.dz) begin
                $error("div_zero: expected %0b, got %0b", e.dz, dz); n_err++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic calm = 1'b0;
    logic stim_done = 1'b0;
    int   stall_cnt = 0;

    cau_req_if #(.DATA_WIDTH(DW)) req_if ();
    cau_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();

    cplx_scoreboard sb = new();

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.req_type = '0;
        req_if.a_real = '0;
        req_if.a_imag = '0;
        req_if.b_real = '0;
        req_if.b_imag = '0;
        rsp_if.ready = 1'b0;
    end

    // Check results and score accepted requests on the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(cau_pkg::t_op'(req_if.req_type), req_if.a_real,
                                req_if.a_imag, req_if.b_real, req_if.b_imag);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.res_real, rsp_if.res_imag,
                                rsp_if.overflow, rsp_if.div_zero);
        end
    end

    // Receiver: random stall bursts until the calm tail.
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 3);
                rsp_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Watchdog: cycles without any transaction.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cnt <= 0;
        else if (i_rst_n)
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    function automatic logic signed [DW-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return DW'($urandom_range(0, 1023)) - 16'sd512;
            default: return DW'($urandom);
        endcase
    endfunction

    // Present one request, hold until accepted, then maybe idle.
    task automatic send_request(cau_pkg::t_op op, logic signed [DW-1:0] ar, ai, br, bi);
        int n;
        req_if.valid <= 1'b1;
        req_if.req_type <= op;
        req_if.a_real <= ar;
        req_if.a_imag <= ai;
        req_if.b_real <= br;
        req_if.b_imag <= bi;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 3);
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    initial begin
        cau_pkg::t_op op;
        logic signed [DW-1:0] mx, mn;
        mx = 16'sh7fff;
        mn = 16'sh8000;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed: extremes, every operation, saturation, zero divisor.
        send_request(cau_pkg::OP_ADD, mx, mx, mx, mx);
        send_request(cau_pkg::OP_ADD, mn, mn, mn, mn);
        send_request(cau_pkg::OP_ADD, 16'sd256, -16'sd128, 16'sd384, 16'sd64);
        send_request(cau_pkg::OP_SUB, mn, mx, mx, mn);
        send_request(cau_pkg::OP_SUB, mx, mn, mn, mx);
        send_request(cau_pkg::OP_SUB, 16'sd100, 16'sd0, 16'sd300, -16'sd5);
        send_request(cau_pkg::OP_MUL, mx, mx, mx, mx);
        send_request(cau_pkg::OP_MUL, mn, mn, mn, mn);
        send_request(cau_pkg::OP_MUL, mn, 16'sd0, mn, 16'sd0);
        send_request(cau_pkg::OP_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0);
        send_request(cau_pkg::OP_MUL, 16'sd256, 16'sd256, 16'sd256, -16'sd256);
        send_request(cau_pkg::OP_MUL, -16'sd3, 16'sd7, 16'sd5, -16'sd11);
        send_request(cau_pkg::OP_DIV, 16'sd256, 16'sd0, 16'sd0, 16'sd0);
        send_request(cau_pkg::OP_DIV, mx, mn, 16'sd0, 16'sd0);
        send_request(cau_pkg::OP_DIV, 16'sd256, 16'sd0, 16'sd768, 16'sd0);
        send_request(cau_pkg::OP_DIV, -16'sd256, 16'sd0, 16'sd768, 16'sd0);
        send_request(cau_pkg::OP_DIV, mx, mx, 16'sd1, 16'sd0);
        send_request(cau_pkg::OP_DIV, mn, mn, 16'sd0, -16'sd1);
        send_request(cau_pkg::OP_DIV, mn, mn, mn, mn);
        send_request(cau_pkg::OP_DIV, mx, 16'sd0, mn, mx);
        send_request(cau_pkg::OP_DIV, 16'sd512, -16'sd256, 16'sd256, 16'sd256);
        send_request(cau_pkg::OP_SUB, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
        for (int k = 0; k < 400; k++) begin
            if (k == 340) calm = 1'b1;
            op = cau_pkg::t_op'($urandom_range(0, 3));
            send_request(op, rand_operand(), rand_operand(),
                         ($urandom_range(0, 15) == 0) ? 16'sd0 : rand_operand(),
                         ($urandom_range(0, 15) == 0) ? 16'sd0 : rand_operand());
        end
        req_if.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.n_err == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
